@@ src/fsc_pkg.sv @@
// shared constants and register codes for the frame smear correction block
`default_nettype none

package fsc_pkg;

   // payload and register widths
   localparam int PIX_W        = 20;
   localparam int SCALAR_W     = 20;
   localparam int SUM_W        = 32;
   localparam int COUNT_REG_W  = 11;
   localparam int CSR_DATA_W   = 20;
   localparam int CSR_INDEX_W  = 2;

   // scalar is Q4.16, product drops the 16 fraction bits of the scalar
   localparam int FRAC_SHIFT   = 16;
   localparam int PROD_FULL_W  = SUM_W + SCALAR_W;
   localparam int PROD_W       = PROD_FULL_W - FRAC_SHIFT;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_SAMPLES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_BANDS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMEAR_SCALAR = 2'd2;

   // reset values of the registers
   localparam int NUM_SAMPLES_RESET = 1024;
   localparam int NUM_BANDS_RESET   = 1024;
   localparam logic [SCALAR_W-1:0] SMEAR_SCALAR_RESET = '0;

   // default sizes
   localparam int DEFAULT_MAX_SAMPLES = 1024;
   localparam int DEFAULT_MAX_BANDS   = 1024;

endpackage

`default_nettype wire

@@ src/frame_smear_correction.sv @@
// top level: frame-transfer smear correction over a running-sum memory
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   req     | req_valid req_stall req_pixel_value | in
//   rsp     | rsp_valid rsp_stall rsp_corrected_value rsp_underflow | out
//   csr     | csr_wen csr_index csr_wdata         | in
//
// stages: memory read and multiply (s1), subtract/accumulate/write back (s2),
// plus an output register; rsp_valid rises when the item reaches it.
// one item per cycle when samples per band is three or more and rsp_stall is low;
// with fewer samples an item waits while an older one on its sum entry is in s1 or s2,
// set by the read-multiply-write loop on the running-sum memory entry.
// reset clears positions and valid bits, sets csrs; a sum is defined once band 0 writes it.
// rsp_stall holds the output register; stages behind it keep filling until full.
`default_nettype none

module frame_smear_correction #(
   parameter int MAX_SAMPLES = fsc_pkg::DEFAULT_MAX_SAMPLES,
   parameter int MAX_BANDS   = fsc_pkg::DEFAULT_MAX_BANDS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [fsc_pkg::PIX_W-1:0]     req_pixel_value,

   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [fsc_pkg::PIX_W-1:0]     rsp_corrected_value,
   output      logic                          rsp_underflow,

   input  wire logic                          csr_wen,
   input  wire logic [fsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SAMPLE_AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int BAND_AW   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int SCNT_W    = $clog2(MAX_SAMPLES + 1);
   localparam int BCNT_W    = $clog2(MAX_BANDS + 1);
   localparam int SCMP_W    = (SCNT_W > fsc_pkg::COUNT_REG_W) ? SCNT_W : fsc_pkg::COUNT_REG_W;
   localparam int BCMP_W    = (BCNT_W > fsc_pkg::COUNT_REG_W) ? BCNT_W : fsc_pkg::COUNT_REG_W;
   localparam int NS_RESET  = (fsc_pkg::NUM_SAMPLES_RESET > MAX_SAMPLES) ?
                              MAX_SAMPLES : fsc_pkg::NUM_SAMPLES_RESET;
   localparam int NB_RESET  = (fsc_pkg::NUM_BANDS_RESET > MAX_BANDS) ?
                              MAX_BANDS : fsc_pkg::NUM_BANDS_RESET;

   // ---------------- configuration ----------------
   logic [SCNT_W-1:0]            num_samples_ff;
   logic [BCNT_W-1:0]            num_bands_ff;
   logic [fsc_pkg::SCALAR_W-1:0] smear_scalar_ff;
   logic [SCNT_W-1:0]            num_samples_in;
   logic [BCNT_W-1:0]            num_bands_in;
   logic [SCMP_W-1:0]            ns_req;
   logic [BCMP_W-1:0]            nb_req;

   // counts are stored already clamped to 1..MAX
   always_comb begin
      ns_req = SCMP_W'(csr_wdata[fsc_pkg::COUNT_REG_W-1:0]);
      nb_req = BCMP_W'(csr_wdata[fsc_pkg::COUNT_REG_W-1:0]);
      if (ns_req == '0) begin
         num_samples_in = SCNT_W'(1);
      end else if (ns_req > SCMP_W'(MAX_SAMPLES)) begin
         num_samples_in = SCNT_W'(MAX_SAMPLES);
      end else begin
         num_samples_in = SCNT_W'(ns_req);
      end
      if (nb_req == '0) begin
         num_bands_in = BCNT_W'(1);
      end else if (nb_req > BCMP_W'(MAX_BANDS)) begin
         num_bands_in = BCNT_W'(MAX_BANDS);
      end else begin
         num_bands_in = BCNT_W'(nb_req);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_samples_ff  <= SCNT_W'(NS_RESET);
         num_bands_ff    <= BCNT_W'(NB_RESET);
         smear_scalar_ff <= fsc_pkg::SMEAR_SCALAR_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            fsc_pkg::CSR_NUM_SAMPLES:  num_samples_ff  <= num_samples_in;
            fsc_pkg::CSR_NUM_BANDS:    num_bands_ff    <= num_bands_in;
            fsc_pkg::CSR_SMEAR_SCALAR: smear_scalar_ff <= csr_wdata[fsc_pkg::SCALAR_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic                      s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic [SAMPLE_AW-1:0]      s1_addr_ff, s2_addr_ff;
   logic [fsc_pkg::PIX_W-1:0] s1_pixel_ff, s2_pixel_ff;
   logic                      s1_band0_ff, s2_band0_ff;
   logic                      out_free, s2_free, s1_free;
   logic                      hazard, accept;

   logic [SAMPLE_AW-1:0]      sample_pos_ff, sample_pos_in;
   logic [BAND_AW-1:0]        band_pos_ff, band_pos_in;
   logic [SCNT_W-1:0]         sample_inc;
   logic [BCNT_W-1:0]         band_inc;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_free  = !s1_valid_ff || s2_free;

   // hold off an item whose sum entry is still being updated by an older one
   assign hazard = (s1_valid_ff && (s1_addr_ff == sample_pos_ff)) ||
                   (s2_valid_ff && (s2_addr_ff == sample_pos_ff));

   assign req_stall = !s1_free || hazard;
   assign accept    = req_valid && !req_stall;

   // position tracking
   always_comb begin
      sample_inc    = SCNT_W'(sample_pos_ff) + SCNT_W'(1);
      band_inc      = BCNT_W'(band_pos_ff) + BCNT_W'(1);
      sample_pos_in = sample_pos_ff;
      band_pos_in   = band_pos_ff;
      if (accept) begin
         if (sample_inc >= num_samples_ff) begin
            sample_pos_in = '0;
            if (band_inc >= num_bands_ff) begin
               band_pos_in = '0;
            end else begin
               band_pos_in = band_inc[BAND_AW-1:0];
            end
         end else begin
            sample_pos_in = sample_inc[SAMPLE_AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_pos_ff <= '0;
         band_pos_ff   <= '0;
      end else begin
         sample_pos_ff <= sample_pos_in;
         band_pos_ff   <= band_pos_in;
      end
   end

   // ---------------- running-sum memory ----------------
   logic [fsc_pkg::SUM_W-1:0] sum_rd;
   logic [fsc_pkg::SUM_W-1:0] sum_wr;
   logic                      sum_we;

   assign sum_we = s2_valid_ff && out_free;

   fsc_ram #(
      .WIDTH (fsc_pkg::SUM_W),
      .DEPTH (MAX_SAMPLES)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (s2_addr_ff),
      .wr_data (sum_wr),
      .rd_en   (accept),
      .rd_addr (sample_pos_ff),
      .rd_data (sum_rd)
   );

   // ---------------- stage 1: read issued, multiply ----------------
   logic [fsc_pkg::PROD_FULL_W-1:0] prod_full;
   logic [fsc_pkg::PROD_W-1:0]      s2_prod_ff;
   logic [fsc_pkg::SUM_W-1:0]       s2_sum_ff;

   assign prod_full = fsc_pkg::PROD_FULL_W'(sum_rd) * fsc_pkg::PROD_FULL_W'(smear_scalar_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= accept;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff  <= sample_pos_ff;
         s1_pixel_ff <= req_pixel_value;
         s1_band0_ff <= (band_pos_ff == '0);
      end
      if (s2_free && s1_valid_ff) begin
         s2_addr_ff  <= s1_addr_ff;
         s2_pixel_ff <= s1_pixel_ff;
         s2_band0_ff <= s1_band0_ff;
         s2_sum_ff   <= sum_rd;
         s2_prod_ff  <= prod_full[fsc_pkg::PROD_FULL_W-1:fsc_pkg::FRAC_SHIFT];
      end
   end

   // ---------------- stage 2: subtract, clamp, accumulate ----------------
   logic [fsc_pkg::PIX_W-1:0] corrected;
   logic                      under;
   logic [fsc_pkg::SUM_W:0]   acc;

   always_comb begin
      acc = '0;
      if (s2_band0_ff) begin
         corrected = s2_pixel_ff;
         under     = 1'b0;
         sum_wr    = fsc_pkg::SUM_W'(s2_pixel_ff);
      end else begin
         under = s2_prod_ff > fsc_pkg::PROD_W'(s2_pixel_ff);
         if (under) begin
            corrected = '0;
         end else begin
            corrected = s2_pixel_ff - s2_prod_ff[fsc_pkg::PIX_W-1:0];
         end
         acc = {1'b0, s2_sum_ff} + (fsc_pkg::SUM_W + 1)'(corrected);
         // saturate at the top of the sum range
         if (acc[fsc_pkg::SUM_W]) begin
            sum_wr = '1;
         end else begin
            sum_wr = acc[fsc_pkg::SUM_W-1:0];
         end
      end
   end

   // ---------------- output register ----------------
   logic [fsc_pkg::PIX_W-1:0] rsp_corrected_ff;
   logic                      rsp_underflow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         rsp_corrected_ff <= corrected;
         rsp_underflow_ff <= under;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_corrected_value = rsp_corrected_ff;
   assign rsp_underflow       = rsp_underflow_ff;

   // ---------------- assertions ----------------
   // a new read never lands on an entry that is being written back
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (accept && sum_we) |-> (s2_addr_ff != sample_pos_ff))
      else $error("sum read collides with write back");

   // clamped results are zero
   a_underflow_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_underflow_ff) |-> (rsp_corrected_ff == '0))
      else $error("underflow with nonzero result");

   // positions move only when an item is taken
   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(sample_pos_ff) && $stable(band_pos_ff)))
      else $error("position moved without an item");

   // a band 0 item never flags underflow
   a_band0_clean: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_band0_ff) |-> !under)
      else $error("band 0 item flagged underflow");

endmodule

`default_nettype wire

@@ src/fsc_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module fsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
